// ===== rtl/core/qrs_pkg.sv =====
// Shared types, widths and codes for the quadratic root solver.
package qrs_pkg;

  localparam int COEF_W   = 16;
  localparam int OUT_FRAC = 16;
  localparam int ROOT_W   = 32;
  // Discriminant b*b - 4ac, signed.
  localparam int D_W      = 2 * COEF_W + 3;
  // Non-negative discriminant as a radicand, padded to an even width.
  localparam int RAD_W    = 2 * COEF_W + 2;
  // Digits of floor(sqrt(D * 2^32)).
  localparam int SQ_W     = RAD_W / 2 + OUT_FRAC;
  // Numerator -b*2^16 +/- sqrt, signed.
  localparam int NUM_W    = SQ_W + 2;

  localparam logic [1:0] KIND_TWO   = 2'd0;
  localparam logic [1:0] KIND_ONE   = 2'd1;
  localparam logic [1:0] KIND_NONE  = 2'd2;
  localparam logic [1:0] KIND_AZERO = 2'd3;

  typedef struct packed {
    logic signed [COEF_W-1:0] coef_a;
    logic signed [COEF_W-1:0] coef_b;
    logic signed [COEF_W-1:0] coef_c;
  } qrs_in_t;

  typedef struct packed {
    logic signed [ROOT_W-1:0] root_one;
    logic signed [ROOT_W-1:0] root_two;
    logic [1:0]               root_kind;
    logic                     saturated;
  } qrs_out_t;

  // Side data that rides along the square root pipeline.
  typedef struct packed {
    logic [1:0]               kind;
    logic signed [COEF_W-1:0] a;
    logic signed [COEF_W-1:0] b;
  } qrs_tag_t;

endpackage

// ===== rtl/core/quadratic_root_solver.sv =====
// Top level of the quadratic root solver: pipeline plus output register and skid stage.
// Takes one coefficient set per cycle and returns one result per set, in order.
// The path from transfer in to the result showing at the output runs through
// two discriminant stages, one stage per square root digit, three numerator
// stages, one stage per quotient bit, a saturation stage and the output
// register. When the output is stalled, one further result lands in a skid
// register and then in_stall rises until the output is taken; throughput is
// one item per cycle otherwise.
module quadratic_root_solver (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  qrs_pkg::qrs_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output qrs_pkg::qrs_out_t out_data
);
  import qrs_pkg::*;

  logic              en;
  logic              d_v, s_v, p_v;
  qrs_tag_t          d_tag, s_tag;
  logic [RAD_W-1:0]  d_rad;
  logic [SQ_W-1:0]   s_root;
  qrs_out_t          p_d;
  logic              out_v_r, skid_v_r;
  qrs_out_t          out_r, skid_r;
  logic              take;

  assign en       = !skid_v_r;
  assign in_stall = skid_v_r;
  assign take     = out_v_r && !out_stall;

  qrs_disc u_disc (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_v    (in_valid),
    .in_d    (in_data),
    .out_v   (d_v),
    .out_tag (d_tag),
    .out_rad (d_rad)
  );

  qrs_sqrt #(.NS(SQ_W)) u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_v     (d_v),
    .in_tag   (d_tag),
    .in_rad   (d_rad),
    .out_v    (s_v),
    .out_tag  (s_tag),
    .out_root (s_root)
  );

  qrs_div #(.W(COEF_W), .NS(SQ_W)) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_v    (s_v),
    .in_tag  (s_tag),
    .in_root (s_root),
    .out_v   (p_v),
    .out_d   (p_d)
  );

  // The pipeline moves only while the skid register is empty.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (take) begin
        out_v_r  <= 1'b1;
        skid_v_r <= 1'b0;
      end
    end else if (p_v) begin
      if (!out_v_r || take) begin
        out_v_r <= 1'b1;
      end else begin
        skid_v_r <= 1'b1;
      end
    end else if (take) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (take) begin
        out_r <= skid_r;
      end
    end else if (p_v) begin
      if (!out_v_r || take) begin
        out_r <= p_d;
      end else begin
        skid_r <= p_d;
      end
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule

// ===== rtl/core/qrs_disc.sv =====
// Two-stage discriminant unit: products, then b*b - 4ac and root classification.
module qrs_disc (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_v,
  input  qrs_pkg::qrs_in_t  in_d,
  output logic              out_v,
  output qrs_pkg::qrs_tag_t out_tag,
  output logic [qrs_pkg::RAD_W-1:0] out_rad
);
  import qrs_pkg::*;

  logic                       v1_r, v2_r;
  logic signed [COEF_W-1:0]   a1_r, b1_r;
  logic signed [2*COEF_W-1:0] bb_r, ac_r;
  logic signed [D_W-1:0]      d;
  logic [1:0]                 kind;
  qrs_tag_t                   tag2_r;
  logic [RAD_W-1:0]           rad2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_v;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a1_r <= in_d.coef_a;
      b1_r <= in_d.coef_b;
      bb_r <= in_d.coef_b * in_d.coef_b;
      ac_r <= in_d.coef_a * in_d.coef_c;
    end
  end

  always_comb begin
    d = D_W'(bb_r) - (D_W'(ac_r) <<< 2);
    if (a1_r == '0) begin
      kind = KIND_AZERO;
    end else if (d[D_W-1]) begin
      kind = KIND_NONE;
    end else if (d == '0) begin
      kind = KIND_ONE;
    end else begin
      kind = KIND_TWO;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tag2_r.kind <= kind;
      tag2_r.a    <= a1_r;
      tag2_r.b    <= b1_r;
      rad2_r      <= d[D_W-1] ? '0 : d[RAD_W-1:0];
    end
  end

  assign out_v   = v2_r;
  assign out_tag = tag2_r;
  assign out_rad = rad2_r;

endmodule

// ===== rtl/core/qrs_sqrt.sv =====
// Pipelined digit-by-digit square root, one result bit per stage.
module qrs_sqrt #(
  parameter int NS = qrs_pkg::SQ_W
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_v,
  input  qrs_pkg::qrs_tag_t in_tag,
  input  logic [2*NS-2*qrs_pkg::OUT_FRAC-1:0] in_rad,
  output logic              out_v,
  output qrs_pkg::qrs_tag_t out_tag,
  output logic [NS-1:0]     out_root
);
  import qrs_pkg::*;

  logic            v_r    [NS];
  qrs_tag_t        tag_r  [NS];
  logic [2*NS-1:0] rad_r  [NS];
  logic [NS+1:0]   rem_r  [NS];
  logic [NS-1:0]   root_r [NS];

  for (genvar k = 0; k < NS; k++) begin : g_stage
    logic            v_p;
    qrs_tag_t        tag_p;
    logic [2*NS-1:0] rad_p;
    logic [NS+1:0]   rem_p;
    logic [NS-1:0]   root_p;
    logic [NS+1:0]   rem_s, trial;
    logic            ge;

    if (k == 0) begin : g_first
      assign v_p    = in_v;
      assign tag_p  = in_tag;
      assign rad_p  = {in_rad, (2 * OUT_FRAC)'(0)};
      assign rem_p  = '0;
      assign root_p = '0;
    end else begin : g_next
      assign v_p    = v_r[k-1];
      assign tag_p  = tag_r[k-1];
      assign rad_p  = rad_r[k-1];
      assign rem_p  = rem_r[k-1];
      assign root_p = root_r[k-1];
    end

    // The remainder never exceeds twice the partial root, so its low bits suffice.
    assign rem_s = {rem_p[NS-1:0], rad_p[2*NS-1:2*NS-2]};
    assign trial = {root_p, 2'b01};
    assign ge    = rem_s >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_p;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        tag_r[k]  <= tag_p;
        rad_r[k]  <= rad_p << 2;
        rem_r[k]  <= ge ? rem_s - trial : rem_s;
        root_r[k] <= {root_p[NS-2:0], ge};
      end
    end
  end

  assign out_v    = v_r[NS-1];
  assign out_tag  = tag_r[NS-1];
  assign out_root = root_r[NS-1];

endmodule

// ===== rtl/core/qrs_div.sv =====
// Two-lane pipelined rounding divider by 2a with Q16.16 saturation.
module qrs_div #(
  parameter int W  = qrs_pkg::COEF_W,
  parameter int NS = qrs_pkg::SQ_W
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_v,
  input  qrs_pkg::qrs_tag_t in_tag,
  input  logic [NS-1:0]     in_root,
  output logic              out_v,
  output qrs_pkg::qrs_out_t out_d
);
  import qrs_pkg::*;

  localparam int QW = NS + 2;
  localparam int QX = (QW > ROOT_W + 1) ? QW : ROOT_W + 1;

  logic                 va_r, vb_r, vc_r, ve_r;
  logic [1:0]           ka_r, kb_r, kc_r, ke_r;
  logic signed [W-1:0]  aa_r;
  logic signed [QW-1:0] num_a_r [2];
  logic [QW-1:0]        un_b_r  [2];
  logic                 neg_b_r [2];
  logic                 neg_c_r [2];
  logic [W-1:0]         ua_b_r;
  logic [QW-1:0]        n_c_r   [2];
  logic [W:0]           dv_c_r;
  logic signed [QW-1:0] nb;
  logic [W-1:0]         ua;

  // Divider pipeline control, shared by both lanes.
  logic                 vd_r [QW];
  logic [1:0]           kd_r [QW];
  logic [W:0]           dvd_r[QW];

  logic [QW-1:0]        q_fin   [2];
  logic                 neg_fin [2];
  logic [ROOT_W-1:0]    res     [2];
  logic                 sat     [2];
  logic [ROOT_W-1:0]    re_r    [2];
  logic                 se_r    [2];

  assign nb = -(QW'(in_tag.b) <<< OUT_FRAC);
  assign ua = aa_r[W-1] ? W'(-aa_r) : W'(aa_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
    end else if (en) begin
      va_r <= in_v;
      vb_r <= va_r;
      vc_r <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ka_r       <= in_tag.kind;
      aa_r       <= in_tag.a;
      num_a_r[0] <= nb + $signed(QW'(in_root));
      num_a_r[1] <= nb - $signed(QW'(in_root));
      kb_r       <= ka_r;
      ua_b_r     <= ua;
      kc_r       <= kb_r;
      dv_c_r     <= {ua_b_r, 1'b0};
    end
  end

  for (genvar l = 0; l < 2; l++) begin : g_lane
    always_ff @(posedge clk) begin
      if (en) begin
        un_b_r[l]  <= num_a_r[l][QW-1] ? QW'(-num_a_r[l]) : QW'(num_a_r[l]);
        neg_b_r[l] <= num_a_r[l][QW-1] != aa_r[W-1];
        // Adding |a| before dividing by 2|a| rounds half away from zero.
        n_c_r[l]   <= un_b_r[l] + QW'(ua_b_r);
        neg_c_r[l] <= neg_b_r[l];
      end
    end

    logic [QW-1:0] n_r [QW];
    logic [W:0]    r_r [QW];
    logic [QW-1:0] q_r [QW];
    logic          g_r [QW];

    for (genvar j = 0; j < QW; j++) begin : g_step
      logic [QW-1:0] n_p, q_p;
      logic [W:0]    r_p, dv_p;
      logic          g_p;
      logic [W+1:0]  r_s;
      logic          ge;

      if (j == 0) begin : g_first
        assign n_p  = n_c_r[l];
        assign r_p  = '0;
        assign q_p  = '0;
        assign g_p  = neg_c_r[l];
        assign dv_p = dv_c_r;
      end else begin : g_next
        assign n_p  = n_r[j-1];
        assign r_p  = r_r[j-1];
        assign q_p  = q_r[j-1];
        assign g_p  = g_r[j-1];
        assign dv_p = dvd_r[j-1];
      end

      assign r_s = {r_p, n_p[QW-1]};
      assign ge  = r_s >= {1'b0, dv_p};

      always_ff @(posedge clk) begin
        if (en) begin
          n_r[j] <= n_p << 1;
          r_r[j] <= ge ? (W+1)'(r_s - {1'b0, dv_p}) : r_s[W:0];
          q_r[j] <= {q_p[QW-2:0], ge};
          g_r[j] <= g_p;
        end
      end
    end

    assign q_fin[l]   = q_r[QW-1];
    assign neg_fin[l] = g_r[QW-1];

    always_comb begin
      logic [QX-1:0] qx;
      qx      = QX'(q_fin[l]);
      sat[l]  = 1'b0;
      res[l]  = qx[ROOT_W-1:0];
      if (neg_fin[l]) begin
        if (qx > QX'(ROOT_W'(1) << (ROOT_W - 1))) begin
          sat[l] = 1'b1;
          res[l] = ROOT_W'(1) << (ROOT_W - 1);
        end else begin
          res[l] = ROOT_W'(0) - qx[ROOT_W-1:0];
        end
      end else if (qx > QX'({1'b0, {(ROOT_W - 1){1'b1}}})) begin
        sat[l] = 1'b1;
        res[l] = {1'b0, {(ROOT_W - 1){1'b1}}};
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        re_r[l] <= res[l];
        se_r[l] <= sat[l];
      end
    end
  end

  for (genvar j = 0; j < QW; j++) begin : g_ctl
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vd_r[j] <= 1'b0;
      end else if (en) begin
        vd_r[j] <= (j == 0) ? vc_r : vd_r[(j == 0) ? 0 : j - 1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        kd_r[j]  <= (j == 0) ? kc_r : kd_r[(j == 0) ? 0 : j - 1];
        dvd_r[j] <= (j == 0) ? dv_c_r : dvd_r[(j == 0) ? 0 : j - 1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ve_r <= 1'b0;
    end else if (en) begin
      ve_r <= vd_r[QW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ke_r <= kd_r[QW-1];
    end
  end

  always_comb begin
    out_d.root_kind = ke_r;
    if (ke_r == KIND_NONE || ke_r == KIND_AZERO) begin
      out_d.root_one  = '0;
      out_d.root_two  = '0;
      out_d.saturated = 1'b0;
    end else begin
      out_d.root_one  = re_r[0];
      out_d.root_two  = re_r[1];
      out_d.saturated = se_r[0] | se_r[1];
    end
  end

  assign out_v = ve_r;

endmodule

// ===== rtl/core/qrs_checker.sv =====
// Port-level checker for the quadratic root solver and its bind.
module qrs_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input qrs_pkg::qrs_in_t  in_data,
  input logic              out_valid,
  input logic              out_stall,
  input qrs_pkg::qrs_out_t out_data
);
  import qrs_pkg::*;

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_data))
    else $error("stalled input transfer changed");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_no_root_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.root_kind == KIND_NONE || out_data.root_kind == KIND_AZERO)
      |-> out_data.root_one == '0 && out_data.root_two == '0 && !out_data.saturated)
    else $error("roots reported without real roots");

  a_double_root: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.root_kind == KIND_ONE |-> out_data.root_one == out_data.root_two)
    else $error("double root fields differ");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_stall) |-> $past(out_valid && out_stall))
    else $error("input stalled without a stalled result");

endmodule

bind quadratic_root_solver qrs_checker u_qrs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
